// ----- sv/ssgn_pkg.sv -----
package ssgn_pkg;

  localparam int MAX_BOXES_DEF = 64;
  localparam int APB_AW = 3;

  localparam logic [15:0] OVERLAP_RESET = 16'd19661;
  localparam logic [15:0] SCORE_RESET = 16'd45875;

  typedef enum logic [0:0] {
    REG_OVERLAP = 1'b0,
    REG_SCORE   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] bottom;
    logic [15:0] right;
    logic [15:0] top;
    logic [15:0] left;
  } box_t;

  typedef struct packed {
    logic        start;
    logic [15:0] thr;
  } iou_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } iou_rsp_t;

endpackage

// ----- sv/ssgn_iou.sv -----
module ssgn_iou import ssgn_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  iou_req_t req,
  input  box_t     box_a,
  input  box_t     box_b,
  output iou_rsp_t rsp
);

  typedef enum logic [2:0] {
    IDLE, M_INTER, M_AREA_A, M_AREA_B, M_LO, M_HI
  } state_t;

  state_t state;
  logic done;
  logic hit;
  logic disj;
  logic [16:0] iw;
  logic [16:0] ih;
  logic signed [17:0] wa;
  logic signed [17:0] ha;
  logic signed [17:0] wb;
  logic signed [17:0] hb;
  logic [15:0] thr;
  logic [33:0] inter;
  logic signed [37:0] acc;
  logic [33:0] lo;

  logic [15:0] ix0, ix1, iy0, iy1;
  logic signed [17:0] iw_raw, ih_raw;
  logic signed [17:0] wa_c, ha_c, wb_c, hb_c;
  logic disj_c;
  logic signed [19:0] mul_a, mul_b;
  logic signed [39:0] prod;
  logic [53:0] lhs, rhs;

  always_comb begin
    ix0 = (box_a.left > box_b.left) ? box_a.left : box_b.left;
    ix1 = (box_a.right < box_b.right) ? box_a.right : box_b.right;
    iy0 = (box_a.top > box_b.top) ? box_a.top : box_b.top;
    iy1 = (box_a.bottom < box_b.bottom) ? box_a.bottom : box_b.bottom;
    iw_raw = $signed({2'b0, ix1}) - $signed({2'b0, ix0}) + 18'sd16;
    ih_raw = $signed({2'b0, iy1}) - $signed({2'b0, iy0}) + 18'sd16;
    wa_c = $signed({2'b0, box_a.right}) - $signed({2'b0, box_a.left}) + 18'sd16;
    ha_c = $signed({2'b0, box_a.bottom}) - $signed({2'b0, box_a.top}) + 18'sd16;
    wb_c = $signed({2'b0, box_b.right}) - $signed({2'b0, box_b.left}) + 18'sd16;
    hb_c = $signed({2'b0, box_b.bottom}) - $signed({2'b0, box_b.top}) + 18'sd16;
    disj_c = (box_a.left > box_b.right) || (box_a.top > box_b.bottom) ||
             (box_a.right < box_b.left) || (box_a.bottom < box_b.top);
  end

  always_comb begin
    case (state)
      M_INTER: begin
        mul_a = $signed({3'b0, iw});
        mul_b = $signed({3'b0, ih});
      end
      M_AREA_A: begin
        mul_a = 20'(wa);
        mul_b = 20'(ha);
      end
      M_AREA_B: begin
        mul_a = 20'(wb);
        mul_b = 20'(hb);
      end
      M_LO: begin
        mul_a = $signed({4'b0, thr});
        mul_b = $signed({2'b0, acc[17:0]});
      end
      M_HI: begin
        mul_a = $signed({4'b0, thr});
        mul_b = $signed({2'b0, acc[35:18]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
    lhs = {4'b0, inter, 16'b0};
    rhs = {prod[35:0], 18'b0} + {20'b0, lo};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (req.start) begin
            disj <= disj_c;
            iw <= iw_raw[17] ? 17'd0 : iw_raw[16:0];
            ih <= ih_raw[17] ? 17'd0 : ih_raw[16:0];
            wa <= wa_c;
            ha <= ha_c;
            wb <= wb_c;
            hb <= hb_c;
            thr <= req.thr;
            state <= M_INTER;
          end
        end
        M_INTER: begin
          inter <= prod[33:0];
          state <= M_AREA_A;
        end
        M_AREA_A: begin
          acc <= prod[37:0];
          state <= M_AREA_B;
        end
        M_AREA_B: begin
          acc <= acc + prod[37:0] - $signed({4'b0, inter});
          state <= M_LO;
        end
        M_LO: begin
          lo <= prod[33:0];
          state <= M_HI;
        end
        M_HI: begin
          hit <= !disj && !acc[37] && (lhs > rhs);
          done <= 1'b1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.hit = hit;

  a_done_after_hi: assert property (@(posedge clk) disable iff (rst)
    (state == M_HI) |=> done) else $error("iou done missing");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("iou done held");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == IDLE)) else $error("iou done while busy");

endmodule

// ----- sv/score_sort_greedy_nms.sv -----
// Loading: a set of N boxes loads at one transfer per cycle; the closing box starts a pass.
// Ranking compares each box's score with every box in turn, through one memory read port.
// Suppression runs each overlap test on the shared multiply unit of ssgn_iou (5 steps/pair).
// Results then leave one at a time, each held until out_ready takes it; no box is taken until the pass is done.
// Reset (rst, synchronous): empty set, thresholds to defaults, no result pending.
module score_sort_greedy_nms import ssgn_pkg::*; #(
  parameter int MAX_BOXES = MAX_BOXES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       left_x,
  input  logic [15:0]       top_y,
  input  logic [15:0]       right_x,
  input  logic [15:0]       bottom_y,
  input  logic [15:0]       box_score,
  input  logic [7:0]        class_tag,
  input  logic              final_box,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       kept_left_x,
  output logic [15:0]       kept_top_y,
  output logic [15:0]       kept_right_x,
  output logic [15:0]       kept_bottom_y,
  output logic [15:0]       kept_score,
  output logic [7:0]        kept_class,
  output logic              box_valid,
  output logic              end_of_set
);

  localparam int IDX_W = $clog2(MAX_BOXES);
  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BOXES);

  typedef enum logic [4:0] {
    LOAD, S_KRD, S_KGET, S_JRD, S_JCMP, S_KWR,
    N_I, N_IR, N_IC, N_J, N_JR, N_JC, N_JW,
    E_I, E_R, E_C, E_OUT
  } state_t;

  state_t state;
  box_t corner_mem [MAX_BOXES];
  logic [15:0] score_mem [MAX_BOXES];
  logic [IDX_W-1:0] rank_mem [MAX_BOXES];

  logic [IDX_W-1:0] rd_addr, rank_rd_addr;
  box_t corner_q;
  logic [15:0] score_q;
  logic [IDX_W-1:0] rank_q;

  logic [CNT_W-1:0] count, n, k, j, i, rank_cnt;
  logic [15:0] sk;
  logic [MAX_BOXES-1:0] supp, keep;
  box_t box_a;
  logic [7:0] pass_class;
  logic [15:0] ovl_thr, scr_thr;
  logic [IDX_W-1:0] last_idx;
  logic any_keep;
  logic in_xfer, out_xfer, cfg_wr;
  box_t in_box;
  iou_req_t iou_req;
  iou_rsp_t iou_rsp;

  assign in_ready = (state == LOAD);
  assign out_valid = (state == E_OUT);
  assign in_xfer = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign kept_class = pass_class;
  assign in_box = '{bottom: bottom_y, right: right_x, top: top_y, left: left_x};
  assign iou_req.start = (state == N_JC);
  assign iou_req.thr = ovl_thr;

  always_comb begin
    prdata = {16'b0, (reg_idx_t'(paddr[2]) == REG_SCORE) ? scr_thr : ovl_thr};
  end

  always_comb begin
    case (state)
      S_KRD: rd_addr = k[IDX_W-1:0];
      S_JRD: rd_addr = j[IDX_W-1:0];
      N_IR, N_JR, E_R: rd_addr = rank_q;
      default: rd_addr = '0;
    endcase
    case (state)
      N_I, E_I: rank_rd_addr = i[IDX_W-1:0];
      N_J: rank_rd_addr = j[IDX_W-1:0];
      default: rank_rd_addr = '0;
    endcase
  end

  always_comb begin
    any_keep = |keep;
    last_idx = '0;
    for (int m = 0; m < MAX_BOXES; m++) begin
      if (keep[m]) last_idx = IDX_W'(m);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && count < MAX_CNT) begin
      corner_mem[count[IDX_W-1:0]] <= in_box;
      score_mem[count[IDX_W-1:0]] <= box_score;
    end
    if (state == S_KWR) rank_mem[rank_cnt[IDX_W-1:0]] <= k[IDX_W-1:0];
    corner_q <= corner_mem[rd_addr];
    score_q <= score_mem[rd_addr];
    rank_q <= rank_mem[rank_rd_addr];
  end

  ssgn_iou u_iou (
    .clk   (clk),
    .rst   (rst),
    .req   (iou_req),
    .box_a (box_a),
    .box_b (corner_q),
    .rsp   (iou_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD;
      count <= '0;
      supp <= '0;
      keep <= '0;
      pass_class <= '0;
      ovl_thr <= OVERLAP_RESET;
      scr_thr <= SCORE_RESET;
    end else begin
      if (cfg_wr) begin
        case (reg_idx_t'(paddr[2]))
          REG_OVERLAP: ovl_thr <= pwdata[15:0];
          REG_SCORE: scr_thr <= pwdata[15:0];
          default: ;
        endcase
      end
      case (state)
        LOAD: begin
          if (in_xfer) begin
            if (count < MAX_CNT) count <= count + 1'b1;
            if (final_box) begin
              pass_class <= class_tag;
              n <= (count < MAX_CNT) ? count + 1'b1 : count;
              count <= '0;
              supp <= '0;
              keep <= '0;
              k <= '0;
              state <= S_KRD;
            end
          end
        end
        S_KRD: begin
          j <= '0;
          rank_cnt <= '0;
          state <= S_KGET;
        end
        S_KGET: begin
          sk <= score_q;
          state <= S_JRD;
        end
        S_JRD: state <= S_JCMP;
        S_JCMP: begin
          if (score_q > sk || (score_q == sk && j < k)) rank_cnt <= rank_cnt + 1'b1;
          if (j == n - 1'b1) begin
            state <= S_KWR;
          end else begin
            j <= j + 1'b1;
            state <= S_JRD;
          end
        end
        S_KWR: begin
          if (k == n - 1'b1) begin
            i <= '0;
            state <= N_I;
          end else begin
            k <= k + 1'b1;
            state <= S_KRD;
          end
        end
        N_I: begin
          if (i == n) begin
            i <= '0;
            state <= E_I;
          end else if (supp[i[IDX_W-1:0]]) begin
            i <= i + 1'b1;
          end else begin
            state <= N_IR;
          end
        end
        N_IR: state <= N_IC;
        N_IC: begin
          box_a <= corner_q;
          keep[i[IDX_W-1:0]] <= (score_q > scr_thr);
          j <= i + 1'b1;
          state <= N_J;
        end
        N_J: begin
          if (j == n) begin
            i <= i + 1'b1;
            state <= N_I;
          end else if (supp[j[IDX_W-1:0]]) begin
            j <= j + 1'b1;
          end else begin
            state <= N_JR;
          end
        end
        N_JR: state <= N_JC;
        N_JC: state <= N_JW;
        N_JW: begin
          if (iou_rsp.done) begin
            if (iou_rsp.hit) supp[j[IDX_W-1:0]] <= 1'b1;
            j <= j + 1'b1;
            state <= N_J;
          end
        end
        E_I: begin
          if (!any_keep) begin
            kept_left_x <= '0;
            kept_top_y <= '0;
            kept_right_x <= '0;
            kept_bottom_y <= '0;
            kept_score <= '0;
            box_valid <= 1'b0;
            end_of_set <= 1'b1;
            state <= E_OUT;
          end else if (!keep[i[IDX_W-1:0]]) begin
            i <= i + 1'b1;
          end else begin
            state <= E_R;
          end
        end
        E_R: state <= E_C;
        E_C: begin
          kept_left_x <= corner_q.left;
          kept_top_y <= corner_q.top;
          kept_right_x <= corner_q.right;
          kept_bottom_y <= corner_q.bottom;
          kept_score <= score_q;
          box_valid <= 1'b1;
          end_of_set <= (i[IDX_W-1:0] == last_idx);
          state <= E_OUT;
        end
        E_OUT: begin
          if (out_xfer) begin
            if (end_of_set) begin
              state <= LOAD;
            end else begin
              i <= i + 1'b1;
              state <= E_I;
            end
          end
        end
        default: state <= LOAD;
      endcase
    end
  end

  a_marker_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !box_valid) |-> end_of_set) else $error("marker without end");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_CNT) else $error("load count overflow");
  a_end_to_load: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && end_of_set) |=> in_ready) else $error("no return to load");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("load during emit");

endmodule
